FILE: sv/prs_pkg.sv
// Shared constants, item types and codes for the preferential rewiring step block.
package prs_pkg;

  localparam int MAX_NODES  = 64;
  localparam int ENTRY_BITS = 16;

  // Field widths of the item ports
  localparam int CMD_W   = 2;
  localparam int IDX_FW  = 6;
  localparam int VAL_FW  = 16;
  localparam int DRAW_W  = 32;
  localparam int DEG_W   = 17;

  // Configuration widths
  localparam int NC_W     = 7;
  localparam int EDGE_W   = 16;
  localparam int KAPPA_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 2;

  localparam logic [NC_W-1:0]    NODE_COUNT_RST = 7'd64;
  localparam logic [EDGE_W-1:0]  EDGE_TOTAL_RST = 16'd1;
  localparam logic [KAPPA_W-1:0] KAPPA_RST      = 16'd256;

  localparam logic [CFG_IX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_EDGE_TOTAL = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_KAPPA      = 2'd2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Derived datapath widths
  localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int ADJ_AW  = 2 * NODE_W;
  localparam int M2_W    = EDGE_W + 1;
  localparam int CUM_W   = ((DEG_W > ENTRY_BITS) ? DEG_W : ENTRY_BITS) + NODE_W + 1;
  localparam int TOT_W   = (((M2_W + 8) > (KAPPA_W + NCNT_W)) ? (M2_W + 8)
                                                             : (KAPPA_W + NCNT_W)) + 1;
  localparam int S_W     = DEG_W + 8 + 1 + NCNT_W;
  localparam int MUL_A_W = DRAW_W;
  localparam int MUL_B_W = TOT_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int QS_W    = TOT_W + 17;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_FW-1:0] row_index;
    logic [IDX_FW-1:0] col_index;
    logic [VAL_FW-1:0] entry_value;
    logic [DRAW_W-1:0] edge_draw;
    logic              side_draw;
    logic [DRAW_W-1:0] node_draw;
  } cmd_item_t;

  typedef struct packed {
    logic [IDX_FW-1:0] old_node;
    logic [IDX_FW-1:0] anchor_node;
    logic [IDX_FW-1:0] new_node;
    logic [VAL_FW-1:0] read_value;
    logic [DEG_W-1:0]  row_degree;
  } res_item_t;

endpackage

FILE: sv/prs_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface prs_cmd_if;
  logic                  valid;
  logic                  ready;
  prs_pkg::cmd_item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/prs_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface prs_res_if;
  logic                  valid;
  logic                  ready;
  prs_pkg::res_item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/prs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module prs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/preferential_rewiring_step_top.sv
// Preferential rewiring step: adjacency/degree stores with write, read and rewiring commands.
//
// After reset the block runs a clearing pass over the adjacency store of
// 2**(2*NODE_W) entries, zeroing the degree store alongside, with ready low;
// configuration writes are taken throughout. One command is in work at a time. A
// write passes WR_A, WR_B, WR_C, FIN_RD and FIN; a read, an unused command or a write
// with an out-of-range index goes straight to FIN_RD and FIN. A rewiring step runs
// six setup states (MUL_E, MUL_K, TOT, MUL_L, MUL_H, Q) around the single shared
// multiplier, then three walks (cumulative degrees, the chosen row, weighted new-node
// pick) over up to n active nodes, limited to one RAM read per cycle, then six
// read-modify-write updates of the stores, each a read state and a write state; a
// step whose degree or row walk misses goes from that walk straight to FIN_RD. A
// finished result sits in an output register, so the next command is accepted while
// it waits to be taken; the following result then holds in the last state until the register is free.
module preferential_rewiring_step_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [prs_pkg::CFG_IX_W-1:0]    cfg_index,
  input  logic [prs_pkg::CFG_W-1:0]       cfg_data,
  prs_cmd_if.sink                         cmd_ch,
  prs_res_if.source                       res_ch
);

  typedef enum logic [17:0] {
    ST_CLR      = 18'h00001,
    ST_IDLE     = 18'h00002,
    ST_MUL_E    = 18'h00004,
    ST_MUL_K    = 18'h00008,
    ST_TOT      = 18'h00010,
    ST_MUL_L    = 18'h00020,
    ST_MUL_H    = 18'h00040,
    ST_Q        = 18'h00080,
    ST_DEG_WALK = 18'h00100,
    ST_ROW_WALK = 18'h00200,
    ST_NEW_WALK = 18'h00400,
    ST_BUMP_RD  = 18'h00800,
    ST_BUMP_WR  = 18'h01000,
    ST_WR_A     = 18'h02000,
    ST_WR_B     = 18'h04000,
    ST_WR_C     = 18'h08000,
    ST_FIN_RD   = 18'h10000,
    ST_FIN      = 18'h20000
  } state_t;

  typedef enum logic [2:0] {
    BMP_OLD_ANC = 3'd0,
    BMP_ANC_OLD = 3'd1,
    BMP_NEW_ANC = 3'd2,
    BMP_ANC_NEW = 3'd3,
    BMP_DEG_OLD = 3'd4,
    BMP_DEG_NEW = 3'd5
  } bump_t;

  state_t state;
  bump_t  bump;

  // Configuration registers
  logic [prs_pkg::NC_W-1:0]    node_count;
  logic [prs_pkg::EDGE_W-1:0]  edge_total;
  logic [prs_pkg::KAPPA_W-1:0] kappa_q8;

  // Latched command and working registers
  prs_pkg::cmd_item_t              item;
  logic [prs_pkg::ADJ_AW-1:0]      clr_cnt;
  logic [prs_pkg::MUL_P_W-1:0]     prod;
  logic [prs_pkg::M2_W-1:0]        target;
  logic [prs_pkg::TOT_W-1:0]       total;
  logic [prs_pkg::TOT_W-1:0]       qlo;
  logic [prs_pkg::TOT_W-1:0]       q;
  logic [prs_pkg::NCNT_W-1:0]      issue_cnt;
  logic                            chk_vld;
  logic [prs_pkg::NODE_W-1:0]      chk_idx;
  logic [prs_pkg::CUM_W-1:0]       cum;
  logic [prs_pkg::S_W-1:0]         s;
  logic [prs_pkg::NODE_W-1:0]      row_sel;
  logic [prs_pkg::NODE_W-1:0]      u_old;
  logic [prs_pkg::NODE_W-1:0]      anchor;
  logic [prs_pkg::NODE_W-1:0]      u_new;
  logic [prs_pkg::DEG_W-1:0]       diff;
  logic [prs_pkg::IDX_FW-1:0]      res_old;
  logic [prs_pkg::IDX_FW-1:0]      res_anchor;
  logic [prs_pkg::IDX_FW-1:0]      res_new;
  logic                            out_valid;
  prs_pkg::res_item_t              out_data;

  // Combinational helpers
  logic [prs_pkg::NCNT_W-1:0]      n;
  logic [prs_pkg::NODE_W-1:0]      n_last;
  logic [prs_pkg::M2_W-1:0]        m2;
  logic [prs_pkg::MUL_A_W-1:0]     mul_a;
  logic [prs_pkg::MUL_B_W-1:0]     mul_b;
  logic [prs_pkg::MUL_P_W-1:0]     mul_p;
  logic [prs_pkg::QS_W-1:0]        q_sum;
  logic [prs_pkg::NODE_W-1:0]      r_idx;
  logic [prs_pkg::NODE_W-1:0]      c_idx;
  logic                            row_ok;
  logic                            item_ok;
  logic                            in_ok;
  logic [prs_pkg::ENTRY_BITS-1:0]  nv;
  logic [prs_pkg::DEG_W-1:0]       diff_w;
  logic [prs_pkg::CUM_W-1:0]       cum_deg;
  logic [prs_pkg::CUM_W-1:0]       cum_row;
  logic [prs_pkg::S_W-1:0]         s_sum;
  logic                            in_xfer;
  logic                            out_xfer;
  logic                            walk_clear;
  logic                            res_load;
  logic [prs_pkg::ADJ_AW-1:0]      bump_adj_addr;
  logic [prs_pkg::NODE_W-1:0]      bump_deg_addr;
  logic                            bump_inc;
  logic                            bump_is_deg;
  prs_pkg::res_item_t              res_next;

  // RAM ports
  logic                            adj_we;
  logic [prs_pkg::ADJ_AW-1:0]      adj_waddr;
  logic [prs_pkg::ENTRY_BITS-1:0]  adj_wdata;
  logic [prs_pkg::ADJ_AW-1:0]      adj_raddr;
  logic [prs_pkg::ENTRY_BITS-1:0]  adj_rdata;
  logic                            deg_we;
  logic [prs_pkg::NODE_W-1:0]      deg_waddr;
  logic [prs_pkg::DEG_W-1:0]       deg_wdata;
  logic [prs_pkg::NODE_W-1:0]      deg_raddr;
  logic [prs_pkg::DEG_W-1:0]       deg_rdata;

  prs_ram #(
    .WIDTH (prs_pkg::ENTRY_BITS),
    .DEPTH (2 ** prs_pkg::ADJ_AW)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  prs_ram #(
    .WIDTH (prs_pkg::DEG_W),
    .DEPTH (2 ** prs_pkg::NODE_W)
  ) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  assign cmd_ch.ready = (state == ST_IDLE);
  assign res_ch.valid = out_valid;
  assign res_ch.data  = out_data;
  assign in_xfer      = cmd_ch.valid && cmd_ch.ready;
  assign out_xfer     = res_ch.valid && res_ch.ready;
  assign res_load     = (state == ST_FIN) && (!out_valid || res_ch.ready);

  // Active node count, clamped to 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n = prs_pkg::NCNT_W'(1);
    end else if (32'(node_count) > 32'(prs_pkg::MAX_NODES)) begin
      n = prs_pkg::NCNT_W'(prs_pkg::MAX_NODES);
    end else begin
      n = prs_pkg::NCNT_W'(node_count);
    end
  end

  assign n_last  = prs_pkg::NODE_W'(n - prs_pkg::NCNT_W'(1));
  assign m2      = {edge_total, 1'b0};
  assign r_idx   = prs_pkg::NODE_W'(item.row_index);
  assign c_idx   = prs_pkg::NODE_W'(item.col_index);
  assign row_ok  = 32'(item.row_index) < 32'(prs_pkg::MAX_NODES);
  assign item_ok = row_ok && (32'(item.col_index) < 32'(prs_pkg::MAX_NODES));
  assign in_ok   = (32'(cmd_ch.data.row_index) < 32'(prs_pkg::MAX_NODES))
                && (32'(cmd_ch.data.col_index) < 32'(prs_pkg::MAX_NODES));
  assign nv      = prs_pkg::ENTRY_BITS'(item.entry_value);
  assign diff_w  = prs_pkg::DEG_W'(nv) - prs_pkg::DEG_W'(adj_rdata);
  assign cum_deg = cum + prs_pkg::CUM_W'(deg_rdata);
  assign cum_row = cum + prs_pkg::CUM_W'(adj_rdata);
  assign s_sum   = s + prs_pkg::S_W'({deg_rdata, 8'd0}) + prs_pkg::S_W'(kappa_q8);
  assign q_sum   = prod[prs_pkg::QS_W-1:0] + prs_pkg::QS_W'(qlo);

  // Walk restarts: before the degree walk and when the degree or row walk hits
  assign walk_clear = (state == ST_Q)
                   || (state == ST_DEG_WALK && chk_vld
                       && cum_deg >= prs_pkg::CUM_W'(target))
                   || (state == ST_ROW_WALK && chk_vld
                       && cum_row >= prs_pkg::CUM_W'(target));

  // Shared multiplier
  always_comb begin
    unique case (state)
      ST_MUL_E: begin
        mul_a = item.edge_draw;
        mul_b = prs_pkg::MUL_B_W'(m2);
      end
      ST_MUL_K: begin
        mul_a = prs_pkg::MUL_A_W'(kappa_q8);
        mul_b = prs_pkg::MUL_B_W'(n);
      end
      ST_MUL_L: begin
        mul_a = prs_pkg::MUL_A_W'(item.node_draw[15:0]);
        mul_b = total;
      end
      ST_MUL_H: begin
        mul_a = prs_pkg::MUL_A_W'(item.node_draw[31:16]);
        mul_b = total;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Store updates of a rewiring step
  always_comb begin
    bump_adj_addr = '0;
    bump_deg_addr = '0;
    bump_inc      = 1'b0;
    unique case (bump)
      BMP_OLD_ANC: bump_adj_addr = {u_old, anchor};
      BMP_ANC_OLD: bump_adj_addr = {anchor, u_old};
      BMP_NEW_ANC: begin
        bump_adj_addr = {u_new, anchor};
        bump_inc      = 1'b1;
      end
      BMP_ANC_NEW: begin
        bump_adj_addr = {anchor, u_new};
        bump_inc      = 1'b1;
      end
      BMP_DEG_OLD: bump_deg_addr = u_old;
      BMP_DEG_NEW: begin
        bump_deg_addr = u_new;
        bump_inc      = 1'b1;
      end
      default: ;
    endcase
  end

  assign bump_is_deg = (bump == BMP_DEG_OLD) || (bump == BMP_DEG_NEW);

  // RAM port control
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = '0;
    adj_wdata = '0;
    adj_raddr = '0;
    deg_we    = 1'b0;
    deg_waddr = '0;
    deg_wdata = '0;
    deg_raddr = '0;
    unique case (state)
      ST_CLR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_cnt;
        deg_we    = 1'b1;
        deg_waddr = clr_cnt[prs_pkg::NODE_W-1:0];
      end
      ST_DEG_WALK, ST_NEW_WALK: begin
        deg_raddr = issue_cnt[prs_pkg::NODE_W-1:0];
      end
      ST_ROW_WALK: begin
        adj_raddr = {row_sel, issue_cnt[prs_pkg::NODE_W-1:0]};
      end
      ST_BUMP_RD: begin
        adj_raddr = bump_adj_addr;
        deg_raddr = bump_deg_addr;
      end
      ST_BUMP_WR: begin
        adj_raddr = bump_adj_addr;
        deg_raddr = bump_deg_addr;
        if (bump_is_deg) begin
          deg_we    = 1'b1;
          deg_waddr = bump_deg_addr;
          deg_wdata = bump_inc ? deg_rdata + prs_pkg::DEG_W'(1)
                               : deg_rdata - prs_pkg::DEG_W'(1);
        end else begin
          adj_we    = 1'b1;
          adj_waddr = bump_adj_addr;
          adj_wdata = bump_inc ? adj_rdata + prs_pkg::ENTRY_BITS'(1)
                               : adj_rdata - prs_pkg::ENTRY_BITS'(1);
        end
      end
      ST_WR_A: begin
        adj_raddr = {r_idx, c_idx};
        deg_raddr = r_idx;
      end
      ST_WR_B: begin
        adj_we    = 1'b1;
        adj_waddr = {r_idx, c_idx};
        adj_wdata = nv;
        deg_we    = 1'b1;
        deg_waddr = r_idx;
        deg_wdata = deg_rdata + diff_w;
        deg_raddr = c_idx;
      end
      ST_WR_C: begin
        adj_we    = 1'b1;
        adj_waddr = {c_idx, r_idx};
        adj_wdata = nv;
        if (c_idx != r_idx) begin
          deg_we    = 1'b1;
          deg_waddr = c_idx;
          deg_wdata = deg_rdata + diff;
        end
      end
      ST_FIN_RD, ST_FIN: begin
        adj_raddr = {r_idx, c_idx};
        deg_raddr = r_idx;
      end
      default: ;
    endcase
  end

  // Result item
  always_comb begin
    res_next             = '0;
    res_next.old_node    = res_old;
    res_next.anchor_node = res_anchor;
    res_next.new_node    = res_new;
    res_next.read_value  = (item.cmd == prs_pkg::CMD_READ && item_ok)
                         ? prs_pkg::VAL_FW'(adj_rdata) : '0;
    res_next.row_degree  = row_ok ? deg_rdata : '0;
  end

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= prs_pkg::NODE_COUNT_RST;
      edge_total <= prs_pkg::EDGE_TOTAL_RST;
      kappa_q8   <= prs_pkg::KAPPA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        prs_pkg::CFG_NODE_COUNT: node_count <= cfg_data[prs_pkg::NC_W-1:0];
        prs_pkg::CFG_EDGE_TOTAL: edge_total <= cfg_data[prs_pkg::EDGE_W-1:0];
        prs_pkg::CFG_KAPPA:      kappa_q8   <= cfg_data[prs_pkg::KAPPA_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      issue_cnt <= '0;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
      bump      <= BMP_OLD_ANC;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end

      // Walk address issue, one read per cycle
      if (walk_clear) begin
        issue_cnt <= '0;
        chk_vld   <= 1'b0;
      end else if (issue_cnt < n) begin
        issue_cnt <= issue_cnt + prs_pkg::NCNT_W'(1);
        chk_vld   <= 1'b1;
        chk_idx   <= issue_cnt[prs_pkg::NODE_W-1:0];
      end else begin
        chk_vld   <= 1'b0;
      end

      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + prs_pkg::ADJ_AW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            item       <= cmd_ch.data;
            res_old    <= '0;
            res_anchor <= '0;
            res_new    <= '0;
            priority case (1'b1)
              cmd_ch.data.cmd == prs_pkg::CMD_WRITE && in_ok: state <= ST_WR_A;
              cmd_ch.data.cmd == prs_pkg::CMD_STEP:           state <= ST_MUL_E;
              default:                                         state <= ST_FIN_RD;
            endcase
          end
        end
        ST_MUL_E: state <= ST_MUL_K;
        ST_MUL_K: begin
          target <= prod[32 +: prs_pkg::M2_W] + prs_pkg::M2_W'(1);
          state  <= ST_TOT;
        end
        ST_TOT: begin
          total <= prs_pkg::TOT_W'({m2, 8'd0}) + prs_pkg::TOT_W'(prod);
          state <= ST_MUL_L;
        end
        ST_MUL_L: state <= ST_MUL_H;
        ST_MUL_H: begin
          qlo   <= prod[16 +: prs_pkg::TOT_W];
          state <= ST_Q;
        end
        ST_Q: begin
          q     <= q_sum[16 +: prs_pkg::TOT_W];
          cum   <= '0;
          state <= ST_DEG_WALK;
        end
        ST_DEG_WALK: begin
          if (chk_vld) begin
            if (cum_deg >= prs_pkg::CUM_W'(target)) begin
              row_sel <= chk_idx;
              state   <= ST_ROW_WALK;
            end else begin
              cum <= cum_deg;
              if (chk_idx == n_last) begin
                state <= ST_FIN_RD;
              end
            end
          end
        end
        ST_ROW_WALK: begin
          if (chk_vld) begin
            cum <= cum_row;
            if (cum_row >= prs_pkg::CUM_W'(target)) begin
              u_old  <= item.side_draw ? row_sel : chk_idx;
              anchor <= item.side_draw ? chk_idx : row_sel;
              s      <= '0;
              state  <= ST_NEW_WALK;
            end else if (chk_idx == n_last) begin
              state <= ST_FIN_RD;
            end
          end
        end
        ST_NEW_WALK: begin
          if (chk_vld) begin
            s <= s_sum;
            if (s_sum > prs_pkg::S_W'(q) || chk_idx == n_last) begin
              u_new      <= (s_sum > prs_pkg::S_W'(q)) ? chk_idx : n_last;
              res_new    <= prs_pkg::IDX_FW'((s_sum > prs_pkg::S_W'(q)) ? chk_idx : n_last);
              res_old    <= prs_pkg::IDX_FW'(u_old);
              res_anchor <= prs_pkg::IDX_FW'(anchor);
              bump       <= BMP_OLD_ANC;
              state      <= ST_BUMP_RD;
            end
          end
        end
        ST_BUMP_RD: state <= ST_BUMP_WR;
        ST_BUMP_WR: begin
          if (bump == BMP_DEG_NEW) begin
            state <= ST_FIN_RD;
          end else begin
            bump  <= bump_t'(bump + 3'd1);
            state <= ST_BUMP_RD;
          end
        end
        ST_WR_A: state <= ST_WR_B;
        ST_WR_B: begin
          diff  <= diff_w;
          state <= ST_WR_C;
        end
        ST_WR_C: state <= ST_FIN_RD;
        ST_FIN_RD: state <= ST_FIN;
        ST_FIN: begin
          if (res_load) begin
            out_data <= res_next;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A command transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != ST_IDLE)
    else $error("command accepted but sequencer stayed idle");

  // Walk checks never run past the last active node
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    chk_vld && (state == ST_DEG_WALK || state == ST_ROW_WALK || state == ST_NEW_WALK)
      |-> chk_idx <= n_last)
    else $error("walk index beyond active node count");

  // Stores are read-only during the walks
  a_walk_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEG_WALK || state == ST_ROW_WALK || state == ST_NEW_WALK)
      |-> !adj_we && !deg_we)
    else $error("store written during a walk");

  // Finishing with a free output register loads a result and returns to idle
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && (!out_valid || res_ch.ready) |=> res_ch.valid && state == ST_IDLE)
    else $error("finished command did not produce a result transfer");

  // The degree walk always has a nonzero target
  a_target_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEG_WALK |-> target != '0)
    else $error("zero walk target");

endmodule
